/* rtl/rfbm_pkg.sv */
// ----------------------------------------------------------------------------
// rfbm_pkg: shared types and constants of the radial frequency bin map
// field widths, register codes, reset values and pipeline step sizes
// ----------------------------------------------------------------------------
package rfbm_pkg;

    // field widths
    localparam int BS_W    = 9;          // block_size register
    localparam int BC_W    = 8;          // bin_count register
    localparam int COORD_W = 8;          // col and row
    localparam int BIN_W   = 8;          // bin result
    localparam int BC2_W   = 2 * BC_W;   // bin_count squared, also quotient width

    // defaults and reset values
    localparam int DEF_MAX_BLOCK_SIZE = 256;
    localparam int BS_RESET           = 16;
    localparam int BC_RESET           = 64;

    // quotient bits per divider stage, root bits per square root stage
    localparam int DIV_STEP = 2;
    localparam int SQ_STEP  = 2;

    // configuration register index
    localparam int CFG_ADDR_W = 1;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BLOCK_SIZE = 1'b0,
        REG_BIN_COUNT  = 1'b1
    } rfbm_reg_t;

    // input word
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } rfbm_in_t;

    // result word
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             in_range;
    } rfbm_out_t;

endpackage

/* rtl/rfbm_front.sv */
// ----------------------------------------------------------------------------
// rfbm_front: quadrant swap, range check and squared radius scaling
// three stages: fold to centre offsets, square, sum and scale by bin_count^2
// ----------------------------------------------------------------------------
module rfbm_front #(
    parameter int  MAX_BLOCK_SIZE = rfbm_pkg::DEF_MAX_BLOCK_SIZE,
    localparam int SIZE_W         = $clog2(MAX_BLOCK_SIZE + 1),
    localparam int MAG_W          = SIZE_W - 1,
    localparam int R2_W           = 2 * MAG_W + 1,
    localparam int NUM_W          = rfbm_pkg::BC2_W + R2_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rfbm_pkg::rfbm_in_t          in_data,
    input  logic [SIZE_W-1:0]           size,
    input  logic [rfbm_pkg::BC2_W-1:0]  bc2,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [NUM_W-1:0]            out_num,
    output logic                        out_ok
);
    import rfbm_pkg::*;

    localparam int STAGES = 3;
    localparam int SQ_W   = 2 * MAG_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;

    logic [MAG_W-1:0]   s1_magc_reg, s1_magr_reg;
    logic               s1_ok_reg;
    logic [SQ_W-1:0]    s2_sqc_reg, s2_sqr_reg;
    logic               s2_ok_reg;
    logic [NUM_W-1:0]   s3_num_reg;
    logic               s3_ok_reg;

    logic [BS_W-1:0]    col_ext, row_ext, size_ext;
    logic               ok_next;
    logic [MAG_W-1:0]   magc_next, magr_next;
    logic [R2_W-1:0]    r2;

    // offset magnitude from the centre after the quadrant swap
    function automatic logic [MAG_W-1:0] fold(input logic [BS_W-1:0] c,
                                              input logic [BS_W-1:0] s);
        logic [BS_W-1:0] h;
        logic [BS_W-1:0] m;
        h = s >> 1;
        m = (c < h) ? c : s - c;
        return m[MAG_W-1:0];
    endfunction

    // ready chain, a stage moves when empty or when its successor moves
    always_comb begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    // stage 1 logic: range check and fold
    always_comb begin
        col_ext   = BS_W'(in_data.col);
        row_ext   = BS_W'(in_data.row);
        size_ext  = BS_W'(size);
        ok_next   = (size != '0) && (col_ext < size_ext) && (row_ext < size_ext);
        magc_next = fold(col_ext, size_ext);
        magr_next = fold(row_ext, size_ext);
    end

    // stage 3 logic: squared radius
    assign r2 = R2_W'(s2_sqc_reg) + R2_W'(s2_sqr_reg);

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_magc_reg <= magc_next;
            s1_magr_reg <= magr_next;
            s1_ok_reg   <= ok_next;
        end
        if (rdy[1]) begin
            s2_sqc_reg <= SQ_W'(s1_magc_reg) * SQ_W'(s1_magc_reg);
            s2_sqr_reg <= SQ_W'(s1_magr_reg) * SQ_W'(s1_magr_reg);
            s2_ok_reg  <= s1_ok_reg;
        end
        if (rdy[2]) begin
            s3_num_reg <= NUM_W'(bc2) * NUM_W'(r2);
            s3_ok_reg  <= s2_ok_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_num   = s3_num_reg;
    assign out_ok    = s3_ok_reg;

endmodule

/* rtl/rfbm_div.sv */
// ----------------------------------------------------------------------------
// rfbm_div: pipelined restoring divider
// scaled squared radius over twice half squared, a few quotient bits a stage
// ----------------------------------------------------------------------------
module rfbm_div #(
    parameter int  MAX_BLOCK_SIZE = rfbm_pkg::DEF_MAX_BLOCK_SIZE,
    localparam int SIZE_W         = $clog2(MAX_BLOCK_SIZE + 1),
    localparam int MAG_W          = SIZE_W - 1,
    localparam int D_W            = 2 * MAG_W + 1,
    localparam int Q_W            = rfbm_pkg::BC2_W,
    localparam int NUM_W          = Q_W + D_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic             in_ok,
    input  logic [D_W-1:0]   den,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Q_W-1:0]   out_quot,
    output logic             out_ok
);
    import rfbm_pkg::*;

    localparam int STAGES = Q_W / DIV_STEP;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] ok_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] vld_src, ok_src;

    // partial remainder and numerator bits shifting out while quotient bits shift in
    logic [D_W-1:0] rem_reg [STAGES];
    logic [Q_W-1:0] nq_reg  [STAGES];
    logic [D_W-1:0] rem_src [STAGES];
    logic [Q_W-1:0] nq_src  [STAGES];
    logic [D_W-1:0] rem_new [STAGES];
    logic [Q_W-1:0] nq_new  [STAGES];

    // the remainder starts as the high numerator bits, known to be below den for positions inside the block
    for (genvar k = 0; k < STAGES; k++) begin : g_src
        if (k == 0) begin : g_first
            assign rem_src[k] = in_num[NUM_W-1:Q_W];
            assign nq_src[k]  = in_num[Q_W-1:0];
        end else begin : g_next
            assign rem_src[k] = rem_reg[k-1];
            assign nq_src[k]  = nq_reg[k-1];
        end
    end
    assign vld_src = {vld_reg[STAGES-2:0], in_valid};
    assign ok_src  = {ok_reg[STAGES-2:0], in_ok};

    // ready chain
    always_comb begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    // compare and subtract steps of every stage
    always_comb begin
        logic [D_W:0]   t;
        logic [D_W-1:0] r;
        logic [Q_W-1:0] q;
        for (int k = 0; k < STAGES; k++) begin
            r = rem_src[k];
            q = nq_src[k];
            for (int j = 0; j < DIV_STEP; j++) begin
                t = {r, q[Q_W-1]};
                q = {q[Q_W-2:0], 1'b0};
                if (t >= {1'b0, den}) begin
                    t    = t - {1'b0, den};
                    q[0] = 1'b1;
                end
                r = t[D_W-1:0];
            end
            rem_new[k] = r;
            nq_new[k]  = q;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) vld_reg[k] <= vld_src[k];
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                rem_reg[k] <= rem_new[k];
                nq_reg[k]  <= nq_new[k];
                ok_reg[k]  <= ok_src[k];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_quot  = nq_reg[STAGES-1];
    assign out_ok    = ok_reg[STAGES-1];

endmodule

/* rtl/rfbm_isqrt.sv */
// ----------------------------------------------------------------------------
// rfbm_isqrt: pipelined integer square root
// digit by digit, a few root bits a stage; out of range words give bin zero
// ----------------------------------------------------------------------------
module rfbm_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rfbm_pkg::BC2_W-1:0]  in_val,
    input  logic                        in_ok,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rfbm_pkg::rfbm_out_t         out_data
);
    import rfbm_pkg::*;

    localparam int STAGES = BIN_W / SQ_STEP;
    localparam int REM_W  = BIN_W + 1;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] ok_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] vld_src, ok_src;

    logic [REM_W-1:0] rem_reg  [STAGES];
    logic [BIN_W-1:0] root_reg [STAGES];
    logic [BC2_W-1:0] v_reg    [STAGES];
    logic [REM_W-1:0] rem_src  [STAGES];
    logic [BIN_W-1:0] root_src [STAGES];
    logic [BC2_W-1:0] v_src    [STAGES];
    logic [REM_W-1:0] rem_new  [STAGES];
    logic [BIN_W-1:0] root_new [STAGES];
    logic [BC2_W-1:0] v_new    [STAGES];

    // stage sources, the first stage starts from an empty root
    for (genvar k = 0; k < STAGES; k++) begin : g_src
        if (k == 0) begin : g_first
            assign rem_src[k]  = '0;
            assign root_src[k] = '0;
            assign v_src[k]    = in_val;
        end else begin : g_next
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
            assign v_src[k]    = v_reg[k-1];
        end
    end
    assign vld_src = {vld_reg[STAGES-2:0], in_valid};
    assign ok_src  = {ok_reg[STAGES-2:0], in_ok};

    // ready chain
    always_comb begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    // one root bit per step: bring down two bits, try 4*root+1
    always_comb begin
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic [REM_W-1:0] r;
        logic [BIN_W-1:0] q;
        logic [BC2_W-1:0] v;
        for (int k = 0; k < STAGES; k++) begin
            r = rem_src[k];
            q = root_src[k];
            v = v_src[k];
            for (int j = 0; j < SQ_STEP; j++) begin
                t     = {r, v[BC2_W-1:BC2_W-2]};
                trial = {1'b0, q, 2'b01};
                v     = {v[BC2_W-3:0], 2'b00};
                if (t >= trial) begin
                    t = t - trial;
                    q = {q[BIN_W-2:0], 1'b1};
                end else begin
                    q = {q[BIN_W-2:0], 1'b0};
                end
                r = t[REM_W-1:0];
            end
            rem_new[k]  = r;
            root_new[k] = q;
            v_new[k]    = v;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) vld_reg[k] <= vld_src[k];
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                rem_reg[k]  <= rem_new[k];
                root_reg[k] <= root_new[k];
                v_reg[k]    <= v_new[k];
                ok_reg[k]   <= ok_src[k];
            end
        end
    end

    // result word, bin forced to zero outside the block
    assign out_valid         = vld_reg[STAGES-1];
    assign out_data.bin      = ok_reg[STAGES-1] ? root_reg[STAGES-1] : '0;
    assign out_data.in_range = ok_reg[STAGES-1];

endmodule

/* rtl/radial_frequency_bin_map_unit.sv */
// ----------------------------------------------------------------------------
// radial_frequency_bin_map_unit: radial bin of a quadrant swapped spectrum block
// pipeline of 3 front stages, 8 divider stages (2 quotient bits each),
// 4 square root stages (2 root bits each); throughput one word per cycle unless m_ready stalls
// synchronous reset empties the pipeline and loads block_size 16, bin_count 64
// ----------------------------------------------------------------------------
module radial_frequency_bin_map_unit #(
    parameter int  MAX_BLOCK_SIZE = rfbm_pkg::DEF_MAX_BLOCK_SIZE,
    localparam int SIZE_W         = $clog2(MAX_BLOCK_SIZE + 1),
    localparam int MAG_W          = SIZE_W - 1,
    localparam int R2_W           = 2 * MAG_W + 1,
    localparam int NUM_W          = rfbm_pkg::BC2_W + R2_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  rfbm_pkg::rfbm_reg_t        cfg_addr,
    input  logic [rfbm_pkg::BS_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rfbm_pkg::rfbm_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rfbm_pkg::rfbm_out_t        m_data
);
    import rfbm_pkg::*;

    localparam int MAX_EVEN = MAX_BLOCK_SIZE - (MAX_BLOCK_SIZE % 2);
    localparam int HSQ_W    = 2 * MAG_W;

    logic [BS_W-1:0]    block_size_reg;
    logic [BC_W-1:0]    bin_count_reg;
    logic [R2_W-1:0]    den_reg;
    logic [BC2_W-1:0]   bc2_reg;

    logic [BS_W-1:0]    bs_even;
    logic [SIZE_W-1:0]  size;
    logic [MAG_W-1:0]   half;
    logic [HSQ_W-1:0]   half_sq;

    logic               f_valid, f_ready, f_ok;
    logic [NUM_W-1:0]   f_num;
    logic               d_valid, d_ready, d_ok;
    logic [BC2_W-1:0]   d_quot;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BS_W'(BS_RESET);
            bin_count_reg  <= BC_W'(BC_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BLOCK_SIZE: block_size_reg <= cfg_wdata;
                REG_BIN_COUNT:  bin_count_reg  <= cfg_wdata[BC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective size: even, saturated at the largest supported block
    always_comb begin
        bs_even = {block_size_reg[BS_W-1:1], 1'b0};
        size    = (bs_even > BS_W'(MAX_EVEN)) ? SIZE_W'(MAX_EVEN) : bs_even[SIZE_W-1:0];
        half    = size[SIZE_W-1:1];
        half_sq = HSQ_W'(half) * HSQ_W'(half);
    end

    // derived constants, needed only a few stages into the pipeline
    always_ff @(posedge aclk) begin
        den_reg <= {half_sq, 1'b0};
        bc2_reg <= BC2_W'(bin_count_reg) * BC2_W'(bin_count_reg);
    end

    rfbm_front #(
        .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .size      (size),
        .bc2       (bc2_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_num   (f_num),
        .out_ok    (f_ok)
    );

    rfbm_div #(
        .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_num    (f_num),
        .in_ok     (f_ok),
        .den       (den_reg),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_quot  (d_quot),
        .out_ok    (d_ok)
    );

    rfbm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_val    (d_quot),
        .in_ok     (d_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid)
        else $error("result word valid right after reset");

    // input back-pressure only when the whole pipeline is full and stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled result word");

    // positions outside the block carry bin zero
    a_out_of_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.in_range) |-> (m_data.bin == '0))
        else $error("nonzero bin for a position outside the block");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: radial_frequency_bin_map_unit
// a table of directed words, then random phases under several block sizes and
// bin counts; every result word is checked field by field against its typed
// value or an in-bench model of quadrant swap, exact integer root and range test
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfbm_pkg::*;

    localparam int LATENCY     = 15;
    localparam int WATCH_LIMIT = 2000;
    localparam int PHASES      = 13;
    localparam int PHASE_WORDS = 150;

    // one directed word with the register settings it runs under
    typedef struct {
        logic [BS_W-1:0]    bs;
        logic [BS_W-1:0]    bcw;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        bit                 typed;
        logic [BIN_W-1:0]   bin;
        bit                 in_range;
    } plan_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    rfbm_reg_t cfg_addr = REG_BLOCK_SIZE;
    logic [BS_W-1:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rfbm_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rfbm_out_t m_data;

    // bench copy of the registers
    logic [BS_W-1:0] cur_bs  = BS_W'(BS_RESET);
    logic [BS_W-1:0] cur_bcw = BS_W'(BC_RESET);

    rfbm_out_t bin_due[$];
    rfbm_out_t due_word;
    bit        typed_use = 1'b0;
    rfbm_out_t typed_word = '0;
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;
    int        ready_left = 0;
    plan_row_t plan[$];

    radial_frequency_bin_map_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // edge length actually used: even, capped at the largest block
    function automatic int unsigned usable_size(logic [BS_W-1:0] bs);
        int unsigned s;
        s = bs & 9'h1FE;
        if (s > DEF_MAX_BLOCK_SIZE)
            s = DEF_MAX_BLOCK_SIZE;
        return s;
    endfunction

    // floor of the square root, one result bit at a time from the top
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // radial bin of one position under the current registers
    function automatic rfbm_out_t radial_bin(rfbm_in_t w);
        rfbm_out_t   o;
        int unsigned size;
        int unsigned half;
        logic [63:0] mc;
        logic [63:0] mr;
        logic [63:0] bc;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] b;
        size = usable_size(cur_bs);
        half = size >> 1;
        o = '0;
        if (size != 0 && w.col < size && w.row < size) begin
            mc = (w.col < half) ? 64'(w.col) : 64'(size - w.col);
            mr = (w.row < half) ? 64'(w.row) : 64'(size - w.row);
            bc = 64'(cur_bcw[BC_W-1:0]);
            num = bc * bc * (mc * mc + mr * mr);
            den = 64'd2 * 64'(half) * 64'(half);
            b = floor_root(num / den);
            if (b > 64'd255)
                b = 64'd255;
            o.bin = b[BIN_W-1:0];
            o.in_range = 1'b1;
        end
        return o;
    endfunction

    function automatic plan_row_t mk(logic [BS_W-1:0] bs, logic [BS_W-1:0] bcw,
                                     logic [7:0] col, logic [7:0] row,
                                     bit typed, logic [7:0] bin, bit inr);
        plan_row_t p;
        p.bs = bs;
        p.bcw = bcw;
        p.col = col;
        p.row = row;
        p.typed = typed;
        p.bin = bin;
        p.in_range = inr;
        return p;
    endfunction

    // checking and expectation tracking at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (bin_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: bin %0d in_range %0d",
                                 m_data.bin, m_data.in_range);
                end else begin
                    due_word = bin_due.pop_front();
                    if (m_data.bin !== due_word.bin ||
                        m_data.in_range !== due_word.in_range) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected bin %0d in_range %0d,",
                                      " got bin %0d in_range %0d"},
                                     due_word.bin, due_word.in_range,
                                     m_data.bin, m_data.in_range);
                    end
                end
            end
            if (s_valid && s_ready)
                bin_due.push_back(typed_use ? typed_word : radial_bin(s_data));
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // receiver: bursts of stall and ready, always ready in the closing phases
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
            ready_left <= 0;
        end else if (ready_left == 0) begin
            m_ready <= ($urandom_range(0, 2) != 0);
            ready_left <= $urandom_range(1, 17);
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        while (quiet_cycles < WATCH_LIMIT)
            @(negedge aclk);
        $display("radial_frequency_bin_map_unit verification failed");
        $finish;
    end

    // offer one word, optionally after a gap; entered and left at a falling edge
    task automatic send_word(rfbm_in_t d, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // stop sending and wait until every expected word is back
    task automatic drain();
        s_valid <= 1'b0;
        while (bin_due.size() != 0)
            @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    // write both registers on consecutive cycles
    task automatic set_config(logic [BS_W-1:0] bs, logic [BS_W-1:0] bcw);
        cfg_we <= 1'b1;
        cfg_addr <= REG_BLOCK_SIZE;
        cfg_wdata <= bs;
        cur_bs = bs;
        @(negedge aclk);
        cfg_addr <= REG_BIN_COUNT;
        cfg_wdata <= bcw;
        cur_bcw = bcw;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_gap();
        return (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    endfunction

    function automatic logic [7:0] pick_coord(int unsigned size);
        if (size != 0 && $urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, size - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        rfbm_in_t        w;
        logic [BS_W-1:0] bs;
        logic [BS_W-1:0] bcw;
        int unsigned     size;

        // directed table; typed rows are read straight off the definition
        plan.push_back(mk(16, 64, 0, 0, 1, 0, 1));        // centre after reset
        plan.push_back(mk(16, 64, 8, 8, 1, 64, 1));       // corner reaches bin_count
        plan.push_back(mk(16, 64, 16, 0, 1, 0, 0));       // column outside
        plan.push_back(mk(16, 64, 0, 16, 1, 0, 0));       // row outside
        plan.push_back(mk(16, 64, 255, 255, 1, 0, 0));
        plan.push_back(mk(16, 64, 7, 9, 0, 0, 0));
        plan.push_back(mk(16, 64, 15, 1, 0, 0, 0));
        plan.push_back(mk(17, 64, 15, 15, 0, 0, 0));      // odd size rounds down
        plan.push_back(mk(17, 64, 16, 3, 1, 0, 0));
        plan.push_back(mk(511, 255, 128, 128, 1, 255, 1)); // size saturates
        plan.push_back(mk(511, 255, 255, 255, 0, 0, 0));
        plan.push_back(mk(511, 255, 0, 0, 1, 0, 1));
        plan.push_back(mk(256, 255, 127, 129, 0, 0, 0));
        plan.push_back(mk(256, 255, 255, 0, 0, 0, 0));
        plan.push_back(mk(1, 64, 0, 0, 1, 0, 0));         // size below two
        plan.push_back(mk(0, 64, 0, 0, 1, 0, 0));
        plan.push_back(mk(2, 1, 1, 1, 1, 1, 1));          // smallest block
        plan.push_back(mk(2, 1, 0, 1, 0, 0, 0));
        plan.push_back(mk(2, 1, 2, 0, 1, 0, 0));
        plan.push_back(mk(3, 255, 1, 1, 1, 255, 1));
        plan.push_back(mk(256, 0, 128, 128, 1, 0, 1));    // zero bin count
        plan.push_back(mk(256, 0, 200, 17, 1, 0, 1));
        plan.push_back(mk(256, 9'h1FF, 128, 0, 0, 0, 0)); // upper data bit dropped
        plan.push_back(mk(257, 128, 128, 128, 0, 0, 0));
        plan.push_back(mk(510, 37, 3, 250, 0, 0, 0));

        // reset
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        foreach (plan[i]) begin
            if (plan[i].bs != cur_bs || plan[i].bcw != cur_bcw) begin
                drain();
                set_config(plan[i].bs, plan[i].bcw);
            end
            w.col = plan[i].col;
            w.row = plan[i].row;
            typed_use = plan[i].typed;
            typed_word.bin = plan[i].bin;
            typed_word.in_range = plan[i].in_range;
            send_word(w, pick_gap());
        end
        typed_use = 1'b0;

        // random phases, extremes first, the last ones without idling
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    bs = 511;
                    bcw = 255;
                end
                1: begin
                    bs = 2;
                    bcw = 1;
                end
                2: begin
                    bs = BS_W'($urandom_range(0, 1));
                    bcw = BS_W'($urandom_range(0, 511));
                end
                3: begin
                    bs = 256;
                    bcw = 0;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: bs = BS_W'(2 * $urandom_range(1, 16));
                        1: bs = BS_W'($urandom_range(0, 511));
                        default: bs = 256;
                    endcase
                    bcw = BS_W'($urandom_range(0, 511));
                end
            endcase
            calm = (p >= PHASES - 2);
            set_config(bs, bcw);
            size = usable_size(bs);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // hold off once until the pipeline is empty
                if (p == 5 && k == PHASE_WORDS / 2)
                    drain();
                w.col = pick_coord(size);
                w.row = pick_coord(size);
                send_word(w, pick_gap());
            end
        end

        drain();
        if (mismatch_count == 0 && bin_due.size() == 0) begin
            $display("radial_frequency_bin_map_unit verification clean");
        end else begin
            $display("radial_frequency_bin_map_unit verification failed");
        end
        $finish;
    end

endmodule
